FILE: src/bgtl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Baked glyph text layout: shared package
// Constants, register codes and the types passed between the layout modules.
// ----------------------------------------------------------------------------
package bgtl_pkg;

    localparam int FIRST_CODE    = 32;
    localparam int GLYPH_COUNT   = 96;
    localparam int GLYPH_IDX_W   = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int CODE_NEWLINE  = 10;
    localparam int CODE_FALLBACK = 63;

    localparam bit FALLBACK_OK = (CODE_FALLBACK >= FIRST_CODE) &&
                                 (CODE_FALLBACK < FIRST_CODE + GLYPH_COUNT);

    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 216;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [15:0] GLYPH_SCALE_RST   = 16'd256;
    localparam logic [19:0] LINE_ADVANCE_RST  = 20'd4096;
    localparam logic [19:0] SCALED_ASCENT_RST = 20'd3277;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_CHAR = 2'd1,
        ACT_END  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH_SCALE   = 2'd0,
        CFG_LINE_ADVANCE  = 2'd1,
        CFG_SCALED_ASCENT = 2'd2,
        CFG_TABLE_READY   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0] glyph_scale;
        logic [19:0] line_advance;
        logic [19:0] scaled_ascent;
        logic        table_ready;
    } t_cfg;

    typedef struct packed {
        logic [9:0]         atlas_left;
        logic [9:0]         atlas_top;
        logic [9:0]         atlas_right;
        logic [9:0]         atlas_bottom;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic [15:0]        advance;
    } t_glyph_entry;

    typedef struct packed {
        logic               fill;
        logic [7:0]         char_code;
        logic [15:0]        advance;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_x;
        logic [9:0]         atlas_bottom;
        logic [9:0]         atlas_right;
        logic [9:0]         atlas_top;
        logic [9:0]         atlas_left;
        logic [6:0]         glyph_index;
    } t_in_data;

    typedef struct packed {
        logic valid;
        logic is_char;
        logic is_end;
        logic is_newline;
        logic glyph_ok;
    } t_item;

    typedef struct packed {
        logic [1:0]         fill;
        logic [30:0]        text_height;
        logic [30:0]        text_width;
        logic [9:0]         uv_bottom;
        logic [9:0]         uv_right;
        logic [9:0]         uv_top;
        logic [9:0]         uv_left;
        logic [23:0]        quad_height;
        logic [23:0]        quad_width;
        logic signed [31:0] quad_y;
        logic signed [31:0] quad_x;
    } t_out_data;

    typedef struct packed {
        logic size_valid;
        logic quad_valid;
    } t_out_user;

    typedef struct packed {
        t_out_user user;
        t_out_data data;
    } t_result;

    function automatic logic signed [31:0] sat_s32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [30:0] sat_u31(input logic [31:0] v);
        return v[31] ? 31'h7FFFFFFF : v[30:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/bgtl_glyph_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph table memory
// One write port and one read port with a registered read, one entry per glyph.
// ----------------------------------------------------------------------------
module bgtl_glyph_ram (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [bgtl_pkg::GLYPH_IDX_W-1:0] i_wr_addr,
    input  wire bgtl_pkg::t_glyph_entry           i_wr_data,
    input  wire logic                             i_rd_en,
    input  wire logic [bgtl_pkg::GLYPH_IDX_W-1:0] i_rd_addr,
    output bgtl_pkg::t_glyph_entry                o_rd_data
);

    bgtl_pkg::t_glyph_entry r_mem [bgtl_pkg::GLYPH_COUNT];
    bgtl_pkg::t_glyph_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: src/bgtl_layout.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Layout stage
// Holds the pen state, scales the looked-up glyph and registers each result.
// ----------------------------------------------------------------------------
module bgtl_layout (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire bgtl_pkg::t_cfg         i_cfg,
    input  wire bgtl_pkg::t_item        i_item,
    input  wire bgtl_pkg::t_glyph_entry i_entry,
    output logic                        o_in_ready,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output bgtl_pkg::t_result           o_out
);

    bgtl_pkg::t_item   r_s1;
    logic              r_seen;
    logic [30:0]       r_pen_x;
    logic [30:0]       r_pen_y;
    logic [30:0]       r_widest;
    logic [15:0]       r_lines;
    logic              r_out_valid;
    bgtl_pkg::t_result r_out;

    logic              n_seen;
    logic [30:0]       n_pen_x;
    logic [30:0]       n_pen_y;
    logic [30:0]       n_widest;
    logic [15:0]       n_lines;
    logic              n_emit;
    bgtl_pkg::t_result n_result;

    logic               w_out_free;
    logic               w_go;
    logic [30:0]        w_px;
    logic [30:0]        w_py;
    logic [30:0]        w_wl;
    logic [15:0]        w_lc;
    logic [30:0]        w_wl_max;
    logic signed [16:0] w_scale_s;
    logic signed [32:0] w_prod_x;
    logic signed [32:0] w_prod_y;
    logic signed [32:0] w_rnd_x;
    logic signed [32:0] w_rnd_y;
    logic signed [24:0] w_off_x;
    logic signed [24:0] w_off_y;
    logic signed [33:0] w_sum_x;
    logic signed [33:0] w_sum_y;
    logic signed [10:0] w_dx;
    logic signed [10:0] w_dy;
    logic signed [27:0] w_prod_w;
    logic signed [27:0] w_prod_h;
    logic [31:0]        w_prod_a;
    logic [32:0]        w_rnd_a;
    logic [24:0]        w_adv;
    logic [31:0]        w_pen_sum;
    logic [31:0]        w_line_sum;
    logic [35:0]        w_hgt_prod;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_go       = r_s1.valid && w_out_free;
    assign o_in_ready = !r_s1.valid || w_out_free;

    assign w_px = r_seen ? r_pen_x  : '0;
    assign w_py = r_seen ? r_pen_y  : 31'(i_cfg.scaled_ascent);
    assign w_wl = r_seen ? r_widest : '0;
    assign w_lc = r_seen ? r_lines  : 16'd1;
    assign w_wl_max = (w_px > w_wl) ? w_px : w_wl;

    assign w_scale_s = $signed({1'b0, i_cfg.glyph_scale});
    assign w_prod_x  = $signed(i_entry.offset_x) * w_scale_s;
    assign w_prod_y  = $signed(i_entry.offset_y) * w_scale_s;
    assign w_rnd_x   = w_prod_x + 33'sd128;
    assign w_rnd_y   = w_prod_y + 33'sd128;
    assign w_off_x   = 25'(w_rnd_x >>> 8);
    assign w_off_y   = 25'(w_rnd_y >>> 8);
    assign w_sum_x   = $signed({3'b000, w_px}) + 34'(w_off_x);
    assign w_sum_y   = $signed({3'b000, w_py}) + 34'(w_off_y);

    assign w_dx      = $signed({1'b0, i_entry.atlas_right}) - $signed({1'b0, i_entry.atlas_left});
    assign w_dy      = $signed({1'b0, i_entry.atlas_bottom}) - $signed({1'b0, i_entry.atlas_top});
    assign w_prod_w  = w_dx * w_scale_s;
    assign w_prod_h  = w_dy * w_scale_s;

    assign w_prod_a  = i_entry.advance * i_cfg.glyph_scale;
    assign w_rnd_a   = {1'b0, w_prod_a} + 33'd128;
    assign w_adv     = w_rnd_a[32:8];
    assign w_pen_sum = {1'b0, w_px} + {7'd0, w_adv};

    assign w_line_sum = {1'b0, w_py} + {12'd0, i_cfg.line_advance};
    assign w_hgt_prod = w_lc * i_cfg.line_advance;

    always_comb begin
        n_seen   = r_seen;
        n_pen_x  = r_pen_x;
        n_pen_y  = r_pen_y;
        n_widest = r_widest;
        n_lines  = r_lines;
        n_emit   = 1'b0;
        n_result = '0;
        if (w_go) begin
            if (r_s1.is_char && i_cfg.table_ready) begin
                n_seen   = 1'b1;
                n_pen_x  = w_px;
                n_pen_y  = w_py;
                n_widest = w_wl;
                n_lines  = w_lc;
                if (r_s1.is_newline) begin
                    n_widest = w_wl_max;
                    n_pen_x  = '0;
                    n_pen_y  = bgtl_pkg::sat_u31(w_line_sum);
                    n_lines  = (w_lc == 16'hFFFF) ? w_lc : w_lc + 16'd1;
                end else if (r_s1.glyph_ok) begin
                    n_pen_x = bgtl_pkg::sat_u31(w_pen_sum);
                    if ((w_prod_w > 28'sd0) && (w_prod_h > 28'sd0)) begin
                        n_emit                    = 1'b1;
                        n_result.user.quad_valid  = 1'b1;
                        n_result.data.quad_x      = bgtl_pkg::sat_s32(w_sum_x);
                        n_result.data.quad_y      = bgtl_pkg::sat_s32(w_sum_y);
                        n_result.data.quad_width  = (w_prod_w > 28'sd16777215) ?
                                                    24'hFFFFFF : w_prod_w[23:0];
                        n_result.data.quad_height = (w_prod_h > 28'sd16777215) ?
                                                    24'hFFFFFF : w_prod_h[23:0];
                        n_result.data.uv_left     = i_entry.atlas_left;
                        n_result.data.uv_top      = i_entry.atlas_top;
                        n_result.data.uv_right    = i_entry.atlas_right;
                        n_result.data.uv_bottom   = i_entry.atlas_bottom;
                    end
                end
            end else if (r_s1.is_end) begin
                n_seen                   = 1'b0;
                n_emit                   = 1'b1;
                n_result.user.size_valid = 1'b1;
                if (i_cfg.table_ready && r_seen) begin
                    n_result.data.text_width  = w_wl_max;
                    n_result.data.text_height = (|w_hgt_prod[35:31]) ?
                                                31'h7FFFFFFF : w_hgt_prod[30:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1 <= i_item;
            end
            r_seen <= n_seen;
            if (w_out_free) begin
                r_out_valid <= w_go && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pen_x  <= n_pen_x;
        r_pen_y  <= n_pen_y;
        r_widest <= n_widest;
        r_lines  <= n_lines;
        if (w_go && n_emit) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

FILE: src/baked_glyph_text_layout_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Baked glyph text layout core
// Lays out text with a baked glyph table: one screen quad per visible glyph
// and the block size at the end of each text.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser: action; tdata: glyph load fields and char_code
//  m_axis    out        tuser: quad_valid, size_valid; tdata: quad, uv, size
//  cfg       in         write enable, register index, write data
//
// One transaction is accepted per cycle unless m_axis stalls. Each result is
// registered after its input is registered. The loop that carries from one
// item to the next is the layout stage pen update, fed by the registered glyph
// table read. Reset is synchronous and active low; the glyph table is not
// cleared. A stall on m_axis holds the layout stage, which then holds s_axis.
// ----------------------------------------------------------------------------
module baked_glyph_text_layout_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // glyph_index, atlas_left, atlas_top, atlas_right, atlas_bottom, offset_x,
    // offset_y, advance, char_code
    input  wire logic [bgtl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action
    input  wire logic [bgtl_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // quad_x, quad_y, quad_width, quad_height, uv_left, uv_top, uv_right,
    // uv_bottom, text_width, text_height
    output logic [bgtl_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // quad_valid, size_valid
    output logic [bgtl_pkg::OUT_USER_W-1:0]          m_axis_tuser,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [bgtl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bgtl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bgtl_pkg::t_cfg         r_cfg;
    bgtl_pkg::t_in_data     w_in;
    bgtl_pkg::t_item        w_item;
    bgtl_pkg::t_glyph_entry w_wr_entry;
    bgtl_pkg::t_glyph_entry w_rd_entry;
    bgtl_pkg::t_result      w_out;
    logic                   w_in_ready;
    logic                   w_accept;
    logic                   w_wr_en;
    logic                   w_rd_en;
    logic [bgtl_pkg::GLYPH_IDX_W-1:0] w_wr_addr;
    logic [bgtl_pkg::GLYPH_IDX_W-1:0] w_rd_addr;
    logic [8:0]             w_code;
    logic [8:0]             w_mapped;
    logic                   w_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glyph_scale   <= bgtl_pkg::GLYPH_SCALE_RST;
            r_cfg.line_advance  <= bgtl_pkg::LINE_ADVANCE_RST;
            r_cfg.scaled_ascent <= bgtl_pkg::SCALED_ASCENT_RST;
            r_cfg.table_ready   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (bgtl_pkg::t_cfg_reg'(i_cfg_index))
                bgtl_pkg::CFG_GLYPH_SCALE:   r_cfg.glyph_scale   <= i_cfg_data[15:0];
                bgtl_pkg::CFG_LINE_ADVANCE:  r_cfg.line_advance  <= i_cfg_data;
                bgtl_pkg::CFG_SCALED_ASCENT: r_cfg.scaled_ascent <= i_cfg_data;
                bgtl_pkg::CFG_TABLE_READY:   r_cfg.table_ready   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_in     = s_axis_tdata;
    assign w_accept = s_axis_tvalid && w_in_ready;

    assign w_code     = {1'b0, w_in.char_code};
    assign w_in_range = (w_code >= 9'(bgtl_pkg::FIRST_CODE)) &&
                        (w_code < 9'(bgtl_pkg::FIRST_CODE + bgtl_pkg::GLYPH_COUNT));
    assign w_mapped   = w_in_range ? w_code : 9'(bgtl_pkg::CODE_FALLBACK);
    assign w_rd_addr  = bgtl_pkg::GLYPH_IDX_W'(w_mapped - 9'(bgtl_pkg::FIRST_CODE));
    assign w_wr_addr  = bgtl_pkg::GLYPH_IDX_W'(w_in.glyph_index);

    assign w_wr_entry.atlas_left   = w_in.atlas_left;
    assign w_wr_entry.atlas_top    = w_in.atlas_top;
    assign w_wr_entry.atlas_right  = w_in.atlas_right;
    assign w_wr_entry.atlas_bottom = w_in.atlas_bottom;
    assign w_wr_entry.offset_x     = w_in.offset_x;
    assign w_wr_entry.offset_y     = w_in.offset_y;
    assign w_wr_entry.advance      = w_in.advance;

    always_comb begin
        w_item            = '0;
        w_wr_en           = 1'b0;
        w_rd_en           = 1'b0;
        w_item.is_newline = (w_in.char_code == 8'(bgtl_pkg::CODE_NEWLINE));
        w_item.glyph_ok   = w_in_range || bgtl_pkg::FALLBACK_OK;
        case (bgtl_pkg::t_action'(s_axis_tuser))
            bgtl_pkg::ACT_LOAD: begin
                w_wr_en = w_accept && ({1'b0, w_in.glyph_index} <
                                       8'(bgtl_pkg::GLYPH_COUNT));
            end
            bgtl_pkg::ACT_CHAR: begin
                w_item.valid   = s_axis_tvalid;
                w_item.is_char = 1'b1;
                w_rd_en        = w_accept;
            end
            bgtl_pkg::ACT_END: begin
                w_item.valid  = s_axis_tvalid;
                w_item.is_end = 1'b1;
            end
            default: ;
        endcase
    end

    bgtl_glyph_ram u_glyph_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_entry)
    );

    bgtl_layout u_layout (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (w_item),
        .i_entry     (w_rd_entry),
        .o_in_ready  (w_in_ready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (w_out)
    );

    assign s_axis_tready = w_in_ready;
    assign m_axis_tdata  = w_out.data;
    assign m_axis_tuser  = w_out.user;

endmodule
`default_nettype wire

FILE: test/layout_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph layout checker
// Watches the input, result and register write channels of the layout core.
// It keeps its own copy of the glyph table, the pen and the registers, works
// out the result of every accepted input transaction and compares each
// accepted result transaction, field by field, with the oldest one awaited.
// ----------------------------------------------------------------------------
module layout_checker
    import bgtl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic [OUT_USER_W-1:0] m_axis_tuser,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_errors
);

    typedef struct {
        bit     quad_valid;
        bit     size_valid;
        longint quad_x;
        longint quad_y;
        longint quad_width;
        longint quad_height;
        longint uv_left;
        longint uv_top;
        longint uv_right;
        longint uv_bottom;
        longint text_width;
        longint text_height;
    } layout_result_t;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint U24_MAX = 64'sd16777215;
    localparam longint U31_MAX = 64'sd2147483647;

    logic [15:0] cfg_scale;
    logic [19:0] cfg_line_step;
    logic [19:0] cfg_ascent;
    logic        cfg_ready;

    logic [9:0]  box_left   [GLYPH_COUNT];
    logic [9:0]  box_top    [GLYPH_COUNT];
    logic [9:0]  box_right  [GLYPH_COUNT];
    logic [9:0]  box_bottom [GLYPH_COUNT];
    logic [15:0] met_off_x  [GLYPH_COUNT];
    logic [15:0] met_off_y  [GLYPH_COUNT];
    logic [15:0] met_adv    [GLYPH_COUNT];

    longint pen_x;
    longint pen_y;
    longint widest_line;
    int     line_count;
    bit     in_text;

    layout_result_t expected_layout_q[$];
    int mismatch_count = 0;

    function automatic longint clamp_range(input longint v, input longint lo,
                                           input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_q8(input longint p);
        return (p + 64'sd128) >>> 8;
    endfunction

    task automatic open_text();
        pen_x       = 0;
        pen_y       = longint'(cfg_ascent);
        widest_line = 0;
        line_count  = 1;
    endtask

    task automatic lay_out_item(input logic [IN_USER_W-1:0] act, input t_in_data d);
        int             code;
        int             idx;
        longint         x0;
        longint         y0;
        longint         w;
        longint         h;
        longint         adv;
        layout_result_t res;
        res = '{default: 0};
        case (act)
            ACT_LOAD: begin
                if (d.glyph_index < GLYPH_COUNT) begin
                    idx             = int'(d.glyph_index);
                    box_left[idx]   = d.atlas_left;
                    box_top[idx]    = d.atlas_top;
                    box_right[idx]  = d.atlas_right;
                    box_bottom[idx] = d.atlas_bottom;
                    met_off_x[idx]  = d.offset_x;
                    met_off_y[idx]  = d.offset_y;
                    met_adv[idx]    = d.advance;
                end
            end
            ACT_CHAR: begin
                if (cfg_ready) begin
                    if (!in_text) begin
                        open_text();
                        in_text = 1'b1;
                    end
                    code = int'(d.char_code);
                    if (code == CODE_NEWLINE) begin
                        if (pen_x > widest_line) begin
                            widest_line = pen_x;
                        end
                        pen_x = 0;
                        pen_y = clamp_range(pen_y + longint'(cfg_line_step), S32_MIN, S32_MAX);
                        if (line_count < 65535) begin
                            line_count++;
                        end
                    end else begin
                        if (code < FIRST_CODE || code >= FIRST_CODE + GLYPH_COUNT) begin
                            code = CODE_FALLBACK;
                        end
                        if (code >= FIRST_CODE && code < FIRST_CODE + GLYPH_COUNT) begin
                            idx = code - FIRST_CODE;
                            x0  = clamp_range(pen_x + round_q8(longint'($signed(met_off_x[idx]))
                                  * longint'(cfg_scale)), S32_MIN, S32_MAX);
                            y0  = clamp_range(pen_y + round_q8(longint'($signed(met_off_y[idx]))
                                  * longint'(cfg_scale)), S32_MIN, S32_MAX);
                            w   = (longint'(box_right[idx]) - longint'(box_left[idx]))
                                  * longint'(cfg_scale);
                            h   = (longint'(box_bottom[idx]) - longint'(box_top[idx]))
                                  * longint'(cfg_scale);
                            adv = round_q8(longint'(met_adv[idx]) * longint'(cfg_scale));
                            pen_x = clamp_range(pen_x + adv, S32_MIN, S32_MAX);
                            if (w > 0 && h > 0) begin
                                res.quad_valid  = 1'b1;
                                res.quad_x      = x0;
                                res.quad_y      = y0;
                                res.quad_width  = clamp_range(w, 0, U24_MAX);
                                res.quad_height = clamp_range(h, 0, U24_MAX);
                                res.uv_left     = longint'(box_left[idx]);
                                res.uv_top      = longint'(box_top[idx]);
                                res.uv_right    = longint'(box_right[idx]);
                                res.uv_bottom   = longint'(box_bottom[idx]);
                                expected_layout_q = {expected_layout_q, res};
                            end
                        end
                    end
                end
            end
            ACT_END: begin
                res.size_valid = 1'b1;
                if (cfg_ready && in_text) begin
                    if (pen_x > widest_line) begin
                        widest_line = pen_x;
                    end
                    res.text_width  = clamp_range(widest_line, 0, U31_MAX);
                    res.text_height = clamp_range(longint'(line_count)
                                      * longint'(cfg_line_step), 0, U31_MAX);
                end
                expected_layout_q = {expected_layout_q, res};
                open_text();
                in_text = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input logic [OUT_USER_W-1:0] user, input t_out_data od);
        layout_result_t want;
        t_out_user      ou;
        ou = t_out_user'(user);
        if (expected_layout_q.size() == 0) begin
            $error("result transaction with no result awaited");
            mismatch_count++;
        end else begin
            want = expected_layout_q.pop_front();
            check_field("quad_valid", longint'(want.quad_valid), longint'(ou.quad_valid));
            check_field("size_valid", longint'(want.size_valid), longint'(ou.size_valid));
            check_field("quad_x", want.quad_x, longint'($signed(od.quad_x)));
            check_field("quad_y", want.quad_y, longint'($signed(od.quad_y)));
            check_field("quad_width", want.quad_width, longint'(od.quad_width));
            check_field("quad_height", want.quad_height, longint'(od.quad_height));
            check_field("uv_left", want.uv_left, longint'(od.uv_left));
            check_field("uv_top", want.uv_top, longint'(od.uv_top));
            check_field("uv_right", want.uv_right, longint'(od.uv_right));
            check_field("uv_bottom", want.uv_bottom, longint'(od.uv_bottom));
            check_field("text_width", want.text_width, longint'(od.text_width));
            check_field("text_height", want.text_height, longint'(od.text_height));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_scale     = GLYPH_SCALE_RST;
            cfg_line_step = LINE_ADVANCE_RST;
            cfg_ascent    = SCALED_ASCENT_RST;
            cfg_ready     = 1'b0;
            open_text();
            in_text = 1'b0;
            expected_layout_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tuser, t_out_data'(m_axis_tdata));
            end
            if (s_axis_tvalid && s_axis_tready) begin
                lay_out_item(s_axis_tuser, t_in_data'(s_axis_tdata));
            end
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_GLYPH_SCALE:   cfg_scale     = i_cfg_data[15:0];
                    CFG_LINE_ADVANCE:  cfg_line_step = i_cfg_data[19:0];
                    CFG_SCALED_ASCENT: cfg_ascent    = i_cfg_data[19:0];
                    CFG_TABLE_READY:   cfg_ready     = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_layout_q.size();
        o_errors  = mismatch_count;
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph layout core testbench
// Fills the glyph table, runs a short directed set of texts over the special
// cases and extreme register settings, then random texts under several
// register settings and three patterns of back-pressure and sender idling.
// The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import bgtl_pkg::*;

    localparam int          SETTLE_CYCLES      = 8;
    localparam int          IDLE_LIMIT         = 5000;
    localparam int          RANDOM_ITEMS       = 1900;
    localparam int          SETTINGS_PER_PHASE = 4;
    localparam logic [1:0]  ACT_UNUSED         = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    wire logic                  s_axis_tready;
    wire logic                  m_axis_tvalid;
    wire logic [OUT_DATA_W-1:0] m_axis_tdata;
    wire logic [OUT_USER_W-1:0] m_axis_tuser;

    int tx_idle_pct  = 33;
    int rx_idle_pct  = 78;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int pending_count;
    int fail_count;

    baked_glyph_text_layout_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    layout_checker u_layout_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending_count),
        .o_errors      (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_in_data noise_payload();
        logic [127:0] raw;
        t_in_data     d;
        raw    = {$urandom, $urandom, $urandom, $urandom};
        d      = raw[IN_DATA_W-1:0];
        d.fill = 1'b0;
        return d;
    endfunction

    function automatic logic [7:0] random_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 8'(CODE_NEWLINE);
        end else if (r < 22) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(FIRST_CODE, FIRST_CODE + GLYPH_COUNT - 1));
    endfunction

    task automatic send_item(input logic [1:0] act, input t_in_data d);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= act;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        if (act != ACT_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic send_char(input logic [7:0] code);
        t_in_data d;
        d           = noise_payload();
        d.char_code = code;
        send_item(ACT_CHAR, d);
    endtask

    task automatic send_end();
        send_item(ACT_END, noise_payload());
    endtask

    task automatic send_text(input int len);
        for (int i = 0; i < len; i++) begin
            send_char(random_code());
        end
        send_end();
    endtask

    task automatic load_entry(input int idx, input int l, input int t, input int r,
                              input int b, input logic [15:0] ox, input logic [15:0] oy,
                              input logic [15:0] adv);
        t_in_data d;
        d              = noise_payload();
        d.glyph_index  = 7'(idx);
        d.atlas_left   = 10'(l);
        d.atlas_top    = 10'(t);
        d.atlas_right  = 10'(r);
        d.atlas_bottom = 10'(b);
        d.offset_x     = ox;
        d.offset_y     = oy;
        d.advance      = adv;
        send_item(ACT_LOAD, d);
    endtask

    task automatic load_random(input int idx);
        int l;
        int t;
        int r;
        int b;
        int swap;
        l = $urandom_range(0, 512);
        r = $urandom_range(0, 512);
        t = $urandom_range(0, 512);
        b = $urandom_range(0, 512);
        if (r < l && $urandom_range(0, 4) != 0) begin
            swap = l;
            l    = r;
            r    = swap;
        end
        if (b < t && $urandom_range(0, 4) != 0) begin
            swap = t;
            t    = b;
            b    = swap;
        end
        load_entry(idx, l, t, r, b, 16'($urandom), 16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 4095)));
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        do @(negedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] scale, input logic [19:0] step,
                             input logic [19:0] ascent, input logic ready);
        quiesce();
        write_reg(CFG_GLYPH_SCALE, 20'(scale));
        write_reg(CFG_LINE_ADVANCE, step);
        write_reg(CFG_SCALED_ASCENT, ascent);
        write_reg(CFG_TABLE_READY, 20'(ready));
    endtask

    initial begin
        int pick;
        int target;
        int r;
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_char("A");
        send_char(8'(CODE_NEWLINE));
        send_end();
        send_item(ACT_UNUSED, noise_payload());

        for (int i = 0; i < GLYPH_COUNT; i++) begin
            load_random(i);
        end
        load_entry(0, 10, 10, 10, 20, 16'h0100, 16'h0100, 16'h0800);
        load_entry(33, 0, 0, 512, 512, 16'h8000, 16'h7FFF, 16'hFFFF);
        load_entry(34, 512, 512, 0, 0, 16'h7FFF, 16'h8000, 16'h0000);
        load_entry(CODE_FALLBACK - FIRST_CODE, 100, 100, 140, 164,
                   16'h0180, 16'hF000, 16'h0A00);
        load_entry(96, 1, 1, 2, 2, 16'h0000, 16'h0000, 16'h0000);
        load_entry(127, 3, 3, 4, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        configure(16'd256, 20'd4096, 20'd3277, 1'b1);
        send_end();
        send_char(8'(CODE_NEWLINE));
        send_char("A");
        send_char("B");
        send_char(" ");
        send_char(8'd0);
        send_char(8'd31);
        send_char(8'd127);
        send_char(8'd128);
        send_char(8'd255);
        send_char("?");
        send_char(8'(CODE_NEWLINE));
        send_char("A");
        send_end();

        configure(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1);
        send_char("A");
        send_char("A");
        send_char(8'(CODE_NEWLINE));
        send_char("A");
        send_end();

        configure(16'd0, 20'd0, 20'd0, 1'b1);
        send_char("A");
        send_end();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 33;
                    rx_idle_pct = 78;
                end
                1: begin
                    tx_idle_pct = 78;
                    rx_idle_pct = 33;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                pick = phase * SETTINGS_PER_PHASE + s;
                case (pick % 6)
                    1: configure(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1);
                    2: configure(16'd0, 20'd0, 20'd0, 1'b1);
                    3: configure(16'($urandom_range(0, 65535)),
                                 20'($urandom_range(0, 20'hFFFFF)),
                                 20'($urandom_range(0, 20'hFFFFF)), 1'b1);
                    4: configure(16'($urandom_range(128, 512)),
                                 20'($urandom_range(2048, 8192)),
                                 20'($urandom_range(0, 8192)), 1'b0);
                    default: configure(16'($urandom_range(128, 512)),
                                       20'($urandom_range(2048, 8192)),
                                       20'($urandom_range(0, 8192)), 1'b1);
                endcase
                target = items_sent + RANDOM_ITEMS / (3 * SETTINGS_PER_PHASE);
                while (items_sent < target) begin
                    r = $urandom_range(0, 99);
                    if (r < 5) begin
                        load_random($urandom_range(0, 127));
                    end else if (r < 7) begin
                        send_item(ACT_UNUSED, noise_payload());
                    end else if (r < 9) begin
                        send_end();
                    end else begin
                        if ($urandom_range(0, 19) == 0) begin
                            len = $urandom_range(100, 220);
                        end else begin
                            len = $urandom_range(0, 30);
                        end
                        if (len > target - items_sent) begin
                            len = target - items_sent;
                        end
                        send_text(len);
                    end
                end
            end
        end

        quiesce();
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
